// ===== design/pwtc_pkg.sv =====
// Shared constants, register codes and the symmetric clamp for the PID unit.
// No dependencies; imported by pid_with_term_clamps_unit.
package pwtc_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int SAMPLE_WIDTH = 16;

	localparam int ERR_W   = SAMPLE_WIDTH + 1;
	localparam int DIFF_W  = SAMPLE_WIDTH + 2;
	localparam int GAIN_W  = 32;
	localparam int SUM_W   = 32;
	localparam int LIM_W   = 15;
	localparam int TERM_W  = LIM_W + 1;
	localparam int TOT_W   = TERM_W + 2;
	localparam int DRIVE_W = SAMPLE_WIDTH;

	localparam int P_W = GAIN_W + ERR_W;
	localparam int I_W = GAIN_W + SUM_W;
	localparam int D_W = GAIN_W + DIFF_W;
	localparam int CLAMP_W = I_W;

	localparam int NUM_REGS = 7;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int ADDR_W   = IDX_W + 2;
	localparam int DATA_W   = 32;

	localparam logic [LIM_W-1:0] LIM_RESET = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_PROP_LIMIT  = 3'd3,
		REG_INTEG_LIMIT = 3'd4,
		REG_DERIV_LIMIT = 3'd5,
		REG_OUT_LIMIT   = 3'd6
	} reg_idx_t;

	// Clamps a signed value to the range from -lim to +lim.
	function automatic logic signed [TERM_W-1:0] clamp_sym(
		input logic signed [CLAMP_W-1:0] v,
		input logic [LIM_W-1:0] lim
	);
		logic signed [CLAMP_W-1:0] hi;
		logic signed [CLAMP_W-1:0] lo;
		hi = CLAMP_W'(lim);
		lo = -hi;
		if (v > hi) begin
			return TERM_W'(hi);
		end else if (v < lo) begin
			return TERM_W'(lo);
		end
		return TERM_W'(v);
	endfunction

endpackage

// ===== design/pid_with_term_clamps_unit.sv =====
// Positional PID controller with clamped P, I and D terms and a clamped sum.
// Depends on pwtc_pkg for widths, register codes and the clamp function.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  req_type, setpoint, measured, error_in
// out      output     out_valid/out_ready drive
// cfg      input      APB (pready high)  7 registers at byte address 4*index
//
// One item per cycle sustained while out_ready does not stall the result register.
// Stages: input register, error and saturated integral, three multiplies,
// then shift, term clamps, sum and output clamp into the result register.
// Reset clears valid bits and the error state, zeroes the gains and sets every limit to full scale.
// A stalled output holds its item; earlier stages keep filling until full.
module pid_with_term_clamps_unit
	import pwtc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	input  logic signed [ERR_W-1:0]   error_in,

	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] drive,

	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready
);

	// Configuration registers.
	logic signed [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [LIM_W-1:0] prop_limit_q, integ_limit_q, deriv_limit_q, out_limit_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			prop_limit_q  <= LIM_RESET;
			integ_limit_q <= LIM_RESET;
			deriv_limit_q <= LIM_RESET;
			out_limit_q   <= LIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PROP_GAIN:   prop_gain_q   <= pwdata;
				REG_INTEG_GAIN:  integ_gain_q  <= pwdata;
				REG_DERIV_GAIN:  deriv_gain_q  <= pwdata;
				REG_PROP_LIMIT:  prop_limit_q  <= pwdata[LIM_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= pwdata[LIM_W-1:0];
				REG_DERIV_LIMIT: deriv_limit_q <= pwdata[LIM_W-1:0];
				REG_OUT_LIMIT:   out_limit_q   <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PROP_GAIN:   prdata = prop_gain_q;
			REG_INTEG_GAIN:  prdata = integ_gain_q;
			REG_DERIV_GAIN:  prdata = deriv_gain_q;
			REG_PROP_LIMIT:  prdata = DATA_W'(prop_limit_q);
			REG_INTEG_LIMIT: prdata = DATA_W'(integ_limit_q);
			REG_DERIV_LIMIT: prdata = DATA_W'(deriv_limit_q);
			REG_OUT_LIMIT:   prdata = DATA_W'(out_limit_q);
			default:         prdata = '0;
		endcase
	end

	// Pipeline flow control: a stage loads when it is empty or its item moves on.
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_out, adv_s1;

	assign ld_out   = !out_valid_q | out_ready;
	assign ld_s3    = !v_s3 | ld_out;
	assign ld_s2    = !v_s2 | ld_s3;
	assign ld_s1    = !v_s1 | ld_s2;
	assign adv_s1   = v_s1 & ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1        <= in_valid;
			if (ld_s2)  v_s2        <= v_s1;
			if (ld_s3)  v_s3        <= v_s2;
			if (ld_out) out_valid_q <= v_s3;
		end
	end

	// Stage 1: the accepted item.
	logic req_type_s1;
	logic signed [SAMPLE_WIDTH-1:0] setpoint_s1, measured_s1;
	logic signed [ERR_W-1:0] error_in_s1;

	always_ff @(posedge clk) begin
		if (in_valid && ld_s1) begin
			req_type_s1 <= req_type;
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
			error_in_s1 <= error_in;
		end
	end

	// Error, saturated integral and error difference.
	logic signed [ERR_W-1:0]  prev_err_q, err_c;
	logic signed [SUM_W-1:0]  err_sum_q, sum_sat_c;
	logic signed [SUM_W:0]    sum_wide_c;
	logic signed [DIFF_W-1:0] diff_c;

	always_comb begin
		if (!req_type_s1) begin
			err_c = ERR_W'(setpoint_s1) - ERR_W'(measured_s1);
		end else begin
			err_c = error_in_s1;
		end
		sum_wide_c = (SUM_W+1)'(err_sum_q) + (SUM_W+1)'(err_c);
		// The two top bits differ only when the 32-bit integral has overflowed.
		if (sum_wide_c[SUM_W] != sum_wide_c[SUM_W-1]) begin
			sum_sat_c = {sum_wide_c[SUM_W], {(SUM_W-1){~sum_wide_c[SUM_W]}}};
		end else begin
			sum_sat_c = sum_wide_c[SUM_W-1:0];
		end
		diff_c = DIFF_W'(err_c) - DIFF_W'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			err_sum_q  <= '0;
		end else if (adv_s1) begin
			prev_err_q <= err_c;
			err_sum_q  <= sum_sat_c;
		end
	end

	logic signed [ERR_W-1:0]  err_s2;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [DIFF_W-1:0] diff_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			err_s2  <= err_c;
			sum_s2  <= sum_sat_c;
			diff_s2 <= diff_c;
		end
	end

	// Stage 2: the three gain products, each exact.
	logic signed [P_W-1:0] p_prod_c, p_prod_s3;
	logic signed [I_W-1:0] i_prod_c, i_prod_s3;
	logic signed [D_W-1:0] d_prod_c, d_prod_s3;

	assign p_prod_c = prop_gain_q * err_s2;
	assign i_prod_c = integ_gain_q * sum_s2;
	assign d_prod_c = deriv_gain_q * diff_s2;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			p_prod_s3 <= p_prod_c;
			i_prod_s3 <= i_prod_c;
			d_prod_s3 <= d_prod_c;
		end
	end

	// Stage 3: floor shift, term clamps, sum and output clamp.
	logic signed [TERM_W-1:0]  p_term_c, i_term_c, d_term_c, total_clamp_c;
	logic signed [TOT_W-1:0]   total_c;
	logic signed [DRIVE_W-1:0] drive_q;

	always_comb begin
		p_term_c = clamp_sym(CLAMP_W'(p_prod_s3 >>> FRAC_BITS), prop_limit_q);
		i_term_c = clamp_sym(CLAMP_W'(i_prod_s3 >>> FRAC_BITS), integ_limit_q);
		d_term_c = clamp_sym(CLAMP_W'(d_prod_s3 >>> FRAC_BITS), deriv_limit_q);
		total_c  = TOT_W'(p_term_c) + TOT_W'(i_term_c) + TOT_W'(d_term_c);
		total_clamp_c = clamp_sym(CLAMP_W'(total_c), out_limit_q);
	end

	always_ff @(posedge clk) begin
		if (ld_out && v_s3) begin
			drive_q <= DRIVE_W'(total_clamp_c);
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// The controller state moves only when an item leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(err_sum_q) && $stable(prev_err_q)))
		else $error("PID state changed without an item");

	// The stored previous error matches the error handed to the multiply stage.
	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (prev_err_q == err_s2))
		else $error("previous error differs from the staged error");

	// An empty result register means the pipeline can always take an item.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

	// A new result only appears after an item occupied the last stage.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ($past(!out_valid_q) || $past(out_ready))) |-> $past(v_s3))
		else $error("result appeared without an item behind it");

endmodule
